@@ sv/assert_macros.svh @@
// assertion macros used by the edge dedup table rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clk_i edge outside reset
`define EDT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on every clk_i edge, reset included
`define EDT_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ sv/edt_pkg.sv @@
// package with the sizes, codes and types of the edge dedup table
`timescale 1ns / 1ps

package edt_pkg;

  // table sizing
  localparam int unsigned CAPACITY = 1024;
  localparam int unsigned ADDR_W   = $clog2(CAPACITY);
  localparam int unsigned FILL_W   = $clog2(CAPACITY + 1);
  localparam int unsigned COUNT_W  = 11;
  localparam int unsigned NODE_W   = 31;
  localparam int unsigned TAG_W    = 32;

  // command codes
  localparam logic CMD_FIND   = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  // result status codes
  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_PRESENT  = 3'd1,
    ST_ABSENT   = 3'd2,
    ST_INVALID  = 3'd3,
    ST_FULL     = 3'd4
  } status_e;

  // controller states, one-hot
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_e;

  // one stored edge
  typedef struct packed {
    logic [NODE_W-1:0] first;
    logic [NODE_W-1:0] second;
    logic [TAG_W-1:0]  tag;
  } edge_t;

  // request to the edge memory
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    edge_t             wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

@@ sv/edt_edge_ram.sv @@
// edge storage: one write port, one read port with registered data
`timescale 1ns / 1ps

module edt_edge_ram
  import edt_pkg::*;
(
  input  logic     clk_i,
  input  ram_req_t req_i,
  output edge_t    rdata_o
);

  edge_t mem_q [CAPACITY];
  edge_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/undirected_edge_dedup_table_core.sv @@
// top level of the undirected edge dedup table
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Append-only table of up to CAPACITY undirected edges (two 31-bit node ids
// and a 32-bit version) held in one memory with one read port and one write
// port. A find or insert beat is checked against all stored edges by a
// linear scan that reads one entry per cycle. A command that scans is
// accepted, reads each stored edge in turn, compares the last edge read,
// sees the end of the scan and then hands its result to the output
// register. Rejected commands, a find on an empty table and inserts that
// need no duplicate check (empty table, or a versioned insert with a
// negative version) go from acceptance straight to the output register. A
// scan stops early on the first match. One command is worked on at a time;
// the next beat is taken as soon as the previous result sits in the output
// register, and a result still waiting there holds off the input.
// No clearing pass is needed after reset: only entries below the fill count
// are ever read.
module undirected_edge_dedup_table_core
  import edt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // command channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               cmd_i,
  input  logic               match_version_i,
  input  logic signed [31:0] from_node_i,
  input  logic signed [31:0] to_node_i,
  input  logic signed [31:0] edge_version_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         status_o,
  output logic [10:0]        entry_count_o
);

  state_e              state_q, state_d;
  logic [FILL_W-1:0]   fill_q, fill_d;
  logic [FILL_W-1:0]   cnt_q, cnt_d;
  logic                cmp_valid_q, cmp_valid_d;
  status_e             res_q, res_d;
  logic                ins_q;
  logic                ver_q;
  logic [NODE_W-1:0]   a_q, b_q;
  logic [TAG_W-1:0]    tag_q;
  logic                out_valid_q, out_valid_d;
  status_e             out_status_q;
  logic [COUNT_W-1:0]  out_count_q;
  ram_req_t            ram_req;
  edge_t               rd_edge;
  edge_t               in_edge;
  edge_t               item_edge;
  logic                accept;
  logic                neg_ends;
  logic                tag_neg;
  logic                full;
  logic                hit;
  logic                scan_end;
  logic                out_load;

  edt_edge_ram u_ram (
    .clk_i  (clk_i),
    .req_i  (ram_req),
    .rdata_o(rd_edge)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign neg_ends   = from_node_i[31] || to_node_i[31];
  assign tag_neg    = edge_version_i[31];
  assign full       = (fill_q == FILL_W'(CAPACITY));

  // edge as it would be stored, from the beat or from the held item
  assign in_edge.first    = from_node_i[NODE_W-1:0];
  assign in_edge.second   = to_node_i[NODE_W-1:0];
  assign in_edge.tag      = match_version_i ? edge_version_i : '0;
  assign item_edge.first  = a_q;
  assign item_edge.second = b_q;
  assign item_edge.tag    = tag_q;

  // compare stage on the entry read in the previous cycle
  always_comb begin
    logic ends;
    ends = ((rd_edge.first == a_q) && (rd_edge.second == b_q)) ||
           ((rd_edge.first == b_q) && (rd_edge.second == a_q));
    hit  = cmp_valid_q && ends && (!ver_q || (rd_edge.tag == tag_q));
  end

  assign scan_end = !cmp_valid_q && (cnt_q == fill_q);
  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  // command sequencing and memory requests
  always_comb begin
    state_d       = state_q;
    fill_d        = fill_q;
    cnt_d         = cnt_q;
    cmp_valid_d   = 1'b0;
    res_d         = res_q;
    ram_req.we    = 1'b0;
    ram_req.waddr = fill_q[ADDR_W-1:0];
    ram_req.wdata = item_edge;
    ram_req.re    = 1'b0;
    ram_req.raddr = cnt_q[ADDR_W-1:0];
    case (state_q)
      S_IDLE: begin
        cnt_d = '0;
        if (accept) begin
          state_d = S_DONE;
          if (neg_ends) begin
            res_d = ST_INVALID;
          end else if (cmd_i == CMD_FIND) begin
            if (match_version_i && tag_neg) begin
              res_d = ST_INVALID;
            end else if (fill_q == '0) begin
              res_d = ST_ABSENT;
            end else begin
              state_d = S_SCAN;
            end
          end else if (full) begin
            res_d = ST_FULL;
          end else if ((match_version_i && tag_neg) || (fill_q == '0)) begin
            // stored right away, no duplicate check needed
            ram_req.we    = 1'b1;
            ram_req.wdata = in_edge;
            fill_d        = fill_q + 1'b1;
            res_d         = ST_INSERTED;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          res_d   = ST_PRESENT;
          state_d = S_DONE;
        end else if (scan_end) begin
          state_d = S_DONE;
          if (ins_q == CMD_INSERT) begin
            ram_req.we = 1'b1;
            fill_d     = fill_q + 1'b1;
            res_d      = ST_INSERTED;
          end else begin
            res_d = ST_ABSENT;
          end
        end else if (cnt_q != fill_q) begin
          ram_req.re  = 1'b1;
          cmp_valid_d = 1'b1;
          cnt_d       = cnt_q + 1'b1;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      cnt_q       <= '0;
      cmp_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      cnt_q       <= cnt_d;
      cmp_valid_q <= cmp_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // item and result payload
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (accept) begin
      ins_q <= cmd_i;
      ver_q <= match_version_i;
      a_q   <= in_edge.first;
      b_q   <= in_edge.second;
      tag_q <= in_edge.tag;
    end
    if (out_load) begin
      out_status_q <= res_q;
      out_count_q  <= COUNT_W'(fill_q);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign entry_count_o = out_count_q;

  `EDT_ASSERT_ALWAYS(a_fill_bound, fill_q <= FILL_W'(CAPACITY), "fill count beyond capacity")
  `EDT_ASSERT(a_fill_step, !$stable(fill_q) |-> (fill_q == $past(fill_q) + 1'b1), "fill count jumped")
  `EDT_ASSERT(a_write_room, ram_req.we |-> !full, "write into a full table")
  `EDT_ASSERT(a_read_stored, ram_req.re |-> (cnt_q < fill_q) && !ram_req.we, "read of an unstored entry")

endmodule
